>>> sv/sorted_stream_merge_assert.svh
// Assertion macros for the sorted stream merge block.
// Included by the module that carries the concurrent checks; no other dependencies.
`ifndef SORTED_STREAM_MERGE_ASSERT_SVH
`define SORTED_STREAM_MERGE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SSM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted_stream_merge: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define SSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted_stream_merge: next-cycle check failed");

`endif

>>> sv/ssm_pkg.sv
// Shared types and constants for the sorted stream merge block.
// No dependencies; imported by ssm_pick and sorted_stream_merge.
package ssm_pkg;

  // Element width, fixed by the payload format.
  localparam int VALUE_WIDTH = 32;
  // Default per-list buffer depth.
  localparam int DEFAULT_BUFFER_DEPTH = 32;

  typedef enum logic [1:0] {
    STAT_DATA  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_ENDED = 2'd2,
    STAT_DONE  = 2'd3
  } status_t;

  typedef struct packed {
    logic                          list_sel;
    logic                          has_value;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          ends_list;
  } item_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] out_value;
    status_t                       status;
    logic                          run_last;
  } result_t;

  // Verdict of the head comparator.
  typedef struct packed {
    logic                          take_second;
    logic signed [VALUE_WIDTH-1:0] value;
  } pick_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_CHECK,
    ST_CMP
  } state_t;

endpackage

>>> sv/ssm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ssm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> sv/ssm_pick.sv
// Head comparator: chooses which buffer head leaves next.
// Depends on ssm_pkg for the element width and the verdict struct.
module ssm_pick (
  input  logic signed [ssm_pkg::VALUE_WIDTH-1:0] first_head,
  input  logic signed [ssm_pkg::VALUE_WIDTH-1:0] second_head,
  input  logic                                   first_avail,
  input  logic                                   second_avail,
  output ssm_pkg::pick_t                         pick
);
  import ssm_pkg::*;

  logic first_less;

  // Signed compare; a tie sends the second list's head first
  assign first_less = first_head < second_head;

  always_comb begin
    pick.take_second = second_avail && (!first_avail || !first_less);
    pick.value       = pick.take_second ? second_head : first_head;
  end

endmodule

>>> sv/sorted_stream_merge.sv
// Two-way merge of ascending signed sequences. Each input transfer tags a value with its
// list and may end that list; values wait in one RAM buffer per list (BUFFER_DEPTH entries).
// After each item the block emits the smaller head while a decision is possible (ties: second
// list first), drains one list once the other has ended, and sends a completion result when
// both lists have ended and drained. Pushes into a full buffer or an ended list are dropped
// and reported. run_last marks the final result of each item. An item is taken in ST_IDLE
// and applied in ST_APPLY; then each merged element passes ST_CHECK (buffer RAM read) and
// ST_CMP (compare and pop through the single head comparator), and a final ST_CHECK ends
// the item. An item dropped because its list has ended goes from ST_APPLY back to ST_IDLE.
// A full result register stalls the sequence wherever a result is due. item_ready is high
// only between items; one finished result may wait in the output register while the next
// item is taken.
`include "sorted_stream_merge_assert.svh"

module sorted_stream_merge #(
  parameter int BUFFER_DEPTH = ssm_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  ssm_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output ssm_pkg::result_t result
);
  import ssm_pkg::*;

  localparam int PTR_W = $clog2(BUFFER_DEPTH);
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

  // True when another result follows for this item, given the buffer state
  function automatic logic more_follow(input logic [CNT_W-1:0] fc,
                                       input logic [CNT_W-1:0] sc,
                                       input logic fe,
                                       input logic se,
                                       input logic wd);
    logic merge_ok;
    logic done_ok;
    merge_ok = (fc != '0 && sc != '0) || (fc != '0 && se) || (sc != '0 && fe);
    done_ok  = !wd && fe && se && fc == '0 && sc == '0;
    return merge_ok || done_ok;
  endfunction

  state_t state, state_next;

  item_t             item_q;
  logic              was_done;
  logic              first_ended, second_ended;
  logic [CNT_W-1:0]  first_count, second_count;
  logic [PTR_W-1:0]  first_rptr, first_wptr, second_rptr, second_wptr;
  logic [VALUE_WIDTH-1:0] first_head, second_head;

  logic    slot_free;
  logic    sel_ended, sel_full, need_emit, apply_go;
  logic    fe_apply, se_apply;
  logic    merge_ok, done_ok;
  logic    emit;
  result_t emit_res;
  logic    push_first, push_second, pop_first, pop_second;
  logic    set_first_end, set_second_end;
  logic    capture;
  logic [CNT_W-1:0] fc_pop, sc_pop;
  pick_t   pick;
  logic    counts_ok, pop_ok, emit_done, emit_ended;

  // Buffers
  ssm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(BUFFER_DEPTH)) u_first_ram (
    .clk   (clk),
    .we    (push_first),
    .waddr (first_wptr),
    .wdata (item_q.value),
    .raddr (first_rptr),
    .rdata (first_head)
  );

  ssm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(BUFFER_DEPTH)) u_second_ram (
    .clk   (clk),
    .we    (push_second),
    .waddr (second_wptr),
    .wdata (item_q.value),
    .raddr (second_rptr),
    .rdata (second_head)
  );

  // Shared head comparator
  ssm_pick u_pick (
    .first_head   ($signed(first_head)),
    .second_head  ($signed(second_head)),
    .first_avail  (first_count != '0),
    .second_avail (second_count != '0),
    .pick         (pick)
  );

  // Decode the held item and the buffer state
  assign slot_free = !result_valid || result_ready;
  assign sel_ended = item_q.list_sel ? second_ended : first_ended;
  assign sel_full  = (item_q.list_sel ? second_count : first_count) == CNT_W'(BUFFER_DEPTH);
  assign need_emit = sel_ended || (item_q.has_value && sel_full);
  assign apply_go  = !need_emit || slot_free;
  assign fe_apply  = first_ended || (!sel_ended && item_q.ends_list && !item_q.list_sel);
  assign se_apply  = second_ended || (!sel_ended && item_q.ends_list && item_q.list_sel);
  assign merge_ok  = (first_count != '0 && second_count != '0)
                  || (first_count != '0 && second_ended)
                  || (second_count != '0 && first_ended);
  assign done_ok   = !was_done && first_ended && second_ended
                  && first_count == '0 && second_count == '0;
  assign fc_pop    = pick.take_second ? first_count : first_count - CNT_W'(1);
  assign sc_pop    = pick.take_second ? second_count - CNT_W'(1) : second_count;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        if (apply_go) state_next = sel_ended ? ST_IDLE : ST_CHECK;
      end
      ST_CHECK: begin
        if (merge_ok) begin
          state_next = ST_CMP;
        end else if (!done_ok || slot_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_CMP: begin
        if (slot_free) state_next = ST_CHECK;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath controls
  always_comb begin
    item_ready     = 1'b0;
    capture        = 1'b0;
    emit           = 1'b0;
    emit_res       = '{out_value: '0, status: STAT_DATA, run_last: 1'b0};
    push_first     = 1'b0;
    push_second    = 1'b0;
    pop_first      = 1'b0;
    pop_second     = 1'b0;
    set_first_end  = 1'b0;
    set_second_end = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        capture    = item_valid;
      end
      ST_APPLY: begin
        if (apply_go) begin
          if (sel_ended) begin
            emit     = 1'b1;
            emit_res = '{out_value: '0, status: STAT_ENDED, run_last: 1'b1};
          end else begin
            if (item_q.has_value) begin
              if (sel_full) begin
                emit     = 1'b1;
                emit_res = '{out_value: '0, status: STAT_FULL,
                             run_last: !more_follow(first_count, second_count,
                                                    fe_apply, se_apply, was_done)};
              end else begin
                push_first  = !item_q.list_sel;
                push_second = item_q.list_sel;
              end
            end
            set_first_end  = item_q.ends_list && !item_q.list_sel;
            set_second_end = item_q.ends_list && item_q.list_sel;
          end
        end
      end
      ST_CHECK: begin
        if (!merge_ok && done_ok && slot_free) begin
          emit     = 1'b1;
          emit_res = '{out_value: '0, status: STAT_DONE, run_last: 1'b1};
        end
      end
      ST_CMP: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_res   = '{out_value: pick.value, status: STAT_DATA,
                         run_last: !more_follow(fc_pop, sc_pop, first_ended,
                                                second_ended, was_done)};
          pop_first  = !pick.take_second;
          pop_second = pick.take_second;
        end
      end
      default: begin
        item_ready = 1'b0;
      end
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the accepted item and whether the merge had already finished
  always_ff @(posedge clk) begin
    if (capture) begin
      item_q   <= item;
      was_done <= first_ended && second_ended;
    end
  end

  // Buffer bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      first_count  <= '0;
      second_count <= '0;
      first_rptr   <= '0;
      first_wptr   <= '0;
      second_rptr  <= '0;
      second_wptr  <= '0;
      first_ended  <= 1'b0;
      second_ended <= 1'b0;
    end else begin
      if (push_first) begin
        first_count <= first_count + CNT_W'(1);
        first_wptr  <= (first_wptr == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : first_wptr + PTR_W'(1);
      end else if (pop_first) begin
        first_count <= first_count - CNT_W'(1);
        first_rptr  <= (first_rptr == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : first_rptr + PTR_W'(1);
      end
      if (push_second) begin
        second_count <= second_count + CNT_W'(1);
        second_wptr  <= (second_wptr == PTR_W'(BUFFER_DEPTH - 1)) ? '0
                                                                  : second_wptr + PTR_W'(1);
      end else if (pop_second) begin
        second_count <= second_count - CNT_W'(1);
        second_rptr  <= (second_rptr == PTR_W'(BUFFER_DEPTH - 1)) ? '0
                                                                  : second_rptr + PTR_W'(1);
      end
      if (set_first_end) first_ended <= 1'b1;
      if (set_second_end) second_ended <= 1'b1;
    end
  end

  // Output register: load on emit, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= emit_res;
    end
  end

  // Terms for the checks
  assign counts_ok  = (first_count <= CNT_W'(BUFFER_DEPTH))
                   && (second_count <= CNT_W'(BUFFER_DEPTH));
  assign pop_ok     = (pop_first && first_count != '0) || (pop_second && second_count != '0);
  assign emit_done  = emit && emit_res.status == STAT_DONE;
  assign emit_ended = emit && emit_res.status == STAT_ENDED;

  // Checks
  `SSM_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, counts_ok)
  `SSM_ASSERT_NOW(a_pop_nonempty, clk, rst, pop_first || pop_second, pop_ok)
  `SSM_ASSERT_NEXT(a_done_last, clk, rst, emit_done, result_valid && result.run_last)
  `SSM_ASSERT_NEXT(a_drop_keeps_end, clk, rst, emit_ended, $stable({first_ended, second_ended}))

endmodule

>>> dv/tb_sorted_stream_merge.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_stream_merge: tagged list items in, merged stream out.
// Depends on ssm_pkg and the sorted_stream_merge RTL; nothing else.

module tb_sorted_stream_merge;
  import ssm_pkg::*;

  localparam int DEPTH = DEFAULT_BUFFER_DEPTH;
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  typedef enum int {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_PATTERN} ready_mode_t;

  // Tracks both list buffers and the merged results still owed by the block.
  class merge_scoreboard;
    logic signed [VALUE_WIDTH-1:0] held_first[$];
    logic signed [VALUE_WIDTH-1:0] held_second[$];
    bit ended_first;
    bit ended_second;
    result_t pending_results[$];
    int errors;

    function new();
      ended_first = 1'b0;
      ended_second = 1'b0;
      errors = 0;
    endfunction

    function int held(bit sel);
      return sel ? held_second.size() : held_first.size();
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function void add_result(logic signed [VALUE_WIDTH-1:0] v, status_t st);
      result_t r;
      r.out_value = (st == STAT_DATA) ? v : '0;
      r.status = st;
      r.run_last = 1'b0;
      pending_results.push_back(r);
    endfunction

    // Predict every result caused by one accepted item transfer.
    function void take_item(item_t it);
      int first_idx;
      bit was_done;
      bit going;
      result_t r;
      first_idx = pending_results.size();
      was_done = ended_first && ended_second;
      going = 1'b1;
      if (it.list_sel ? ended_second : ended_first) begin
        add_result('0, STAT_ENDED);
      end else begin
        if (it.has_value) begin
          if (held(it.list_sel) >= DEPTH) begin
            add_result('0, STAT_FULL);
          end else if (it.list_sel) begin
            held_second.push_back(it.value);
          end else begin
            held_first.push_back(it.value);
          end
        end
        if (it.ends_list) begin
          if (it.list_sel) ended_second = 1'b1;
          else ended_first = 1'b1;
        end
        // Emit heads while a decision is possible; a tie sends the second list first.
        while (going) begin
          if (held_first.size() > 0 && held_second.size() > 0) begin
            if (held_first[0] < held_second[0]) add_result(held_first.pop_front(), STAT_DATA);
            else add_result(held_second.pop_front(), STAT_DATA);
          end else if (held_first.size() > 0 && ended_second) begin
            add_result(held_first.pop_front(), STAT_DATA);
          end else if (held_second.size() > 0 && ended_first) begin
            add_result(held_second.pop_front(), STAT_DATA);
          end else begin
            going = 1'b0;
          end
        end
        if (!was_done && ended_first && ended_second &&
            held_first.size() == 0 && held_second.size() == 0)
          add_result('0, STAT_DONE);
      end
      // Mark the final result of this item.
      if (pending_results.size() > first_idx) begin
        r = pending_results[pending_results.size()-1];
        r.run_last = 1'b1;
        pending_results[pending_results.size()-1] = r;
      end
    endfunction

    function void flag(string field, logic [VALUE_WIDTH-1:0] want, logic [VALUE_WIDTH-1:0] got);
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
    endfunction

    // Compare one result transfer with the oldest prediction.
    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unexpected result: expected none, actual value %0h status %0d last %0b",
                   $time, got.out_value, got.status, got.run_last);
        return;
      end
      want = pending_results.pop_front();
      if (got.out_value !== want.out_value) flag("out_value", want.out_value, got.out_value);
      if (got.status !== want.status)
        flag("status", VALUE_WIDTH'(want.status), VALUE_WIDTH'(got.status));
      if (got.run_last !== want.run_last)
        flag("run_last", VALUE_WIDTH'(want.run_last), VALUE_WIDTH'(got.run_last));
    endfunction
  endclass

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  merge_scoreboard sb;
  logic signed [VALUE_WIDTH-1:0] last_val [2];
  int burst_left;
  ready_mode_t ready_mode;
  int unsigned ready_left = 0;
  logic [7:0] ready_pattern = 8'b1101_0010;

  sorted_stream_merge #(.BUFFER_DEPTH(DEPTH)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Check every result transfer at the rising edge.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
  end

  // Stall the result side in segments of varying style.
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      ready_left = $urandom_range(16, 96);
    end
    ready_left--;
    case (ready_mode)
      RDY_ALWAYS: result_ready <= 1'b1;
      RDY_HALF:   result_ready <= ($urandom_range(0, 1) == 1);
      RDY_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
      default: begin
        result_ready <= ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
      end
    endcase
  end

  function automatic item_t make_item(bit sel, bit has, logic signed [VALUE_WIDTH-1:0] v,
                                      bit ends);
    item_t it;
    it.list_sel = sel;
    it.has_value = has;
    it.value = v;
    it.ends_list = ends;
    return it;
  endfunction

  // Next element of an ascending list, with some ties and some unsorted noise.
  function automatic logic signed [VALUE_WIDTH-1:0] next_value(bit sel);
    longint v;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    v = longint'(last_val[sel]);
    if (pick < 10) return $urandom;
    if (pick < 20 && last_val[!sel] > last_val[sel]) v = longint'(last_val[!sel]);
    else if (pick >= 40 && pick < 70) v += longint'($urandom_range(1, 16));
    else if (pick >= 70) v += longint'($urandom_range(0, 1 << 27));
    if (v > longint'(VAL_MAX)) v = longint'(VAL_MAX);
    last_val[sel] = v[VALUE_WIDTH-1:0];
    return last_val[sel];
  endfunction

  // Pick the list that holds data; the other one is then empty.
  function automatic bit busy_list();
    if (sb.held(1'b0) > 0) return 1'b0;
    if (sb.held(1'b1) > 0) return 1'b1;
    return ($urandom_range(0, 1) == 1);
  endfunction

  // Drive one item in bursts with random gaps, hold it until the transfer.
  task automatic send_item(item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.take_item(it);
    @(negedge clk);
  endtask

  // Hold off the sender until every predicted result has come out.
  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(negedge clk); while (sb.outstanding() != 0);
    burst_left = 0;
  endtask

  // Fill one list past its buffer; closing puts the top value last and ends the list.
  task automatic fill_list(bit sel, int extra, bit closing);
    int room;
    logic signed [VALUE_WIDTH-1:0] v;
    room = DEPTH - sb.held(sel);
    for (int k = 0; k < room + extra; k++) begin
      v = (closing && k == room - 1) ? VAL_MAX : next_value(sel);
      send_item(make_item(sel, 1'b1, v, closing && (k == room + extra - 1)));
    end
  endtask

  initial begin
    int eff;
    int extra;
    bit sel;
    bit fill_sel;
    bit end_sel;
    item_valid = 1'b0;
    item = '0;
    rst = 1'b1;
    burst_left = 0;
    last_val[0] = VAL_MIN;
    last_val[1] = VAL_MIN;
    sb = new();
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Items with neither value nor end mark: no effect.
    send_item(make_item(1'b0, 1'b0, '0, 1'b0));
    send_item(make_item(1'b1, 1'b0, '0, 1'b0));
    // Most negative values and ties between the lists.
    send_item(make_item(1'b0, 1'b1, VAL_MIN, 1'b0));
    send_item(make_item(1'b1, 1'b1, VAL_MIN, 1'b0));
    send_item(make_item(1'b1, 1'b1, VAL_MIN, 1'b0));
    send_item(make_item(1'b1, 1'b1, -1, 1'b0));
    send_item(make_item(1'b0, 1'b1, -1, 1'b0));
    // Several heads leave on one item.
    send_item(make_item(1'b0, 1'b1, 0, 1'b0));
    send_item(make_item(1'b0, 1'b1, 5, 1'b0));
    send_item(make_item(1'b1, 1'b1, 3, 1'b0));
    send_item(make_item(1'b1, 1'b1, 7, 1'b0));
    last_val[0] = 5;
    last_val[1] = 7;
    wait_drained();

    // Random interleaving of both lists, with one overflow burst.
    eff = 0;
    while (eff < 110) begin
      if (eff == 40) begin
        fill_sel = busy_list();
        extra = $urandom_range(1, 3);
        eff += DEPTH - sb.held(fill_sel) + extra;
        fill_list(fill_sel, extra, 1'b0);
      end else if ($urandom_range(0, 99) < 8) begin
        send_item(make_item($urandom_range(0, 1) == 1, 1'b0, $urandom, 1'b0));
      end else begin
        sel = ($urandom_range(0, 1) == 1);
        send_item(make_item(sel, 1'b1, next_value(sel), 1'b0));
        eff++;
        if ($urandom_range(0, 99) < 3) wait_drained();
      end
    end

    // Fill one list and end it on the overflowing push; nothing drains yet.
    end_sel = busy_list();
    fill_list(end_sel, 1, 1'b1);
    // Drop anything sent to the ended list.
    send_item(make_item(end_sel, 1'b1, $urandom, 1'b0));
    send_item(make_item(end_sel, 1'b0, '0, 1'b1));
    send_item(make_item(end_sel, 1'b0, '0, 1'b0));
    // Merge the open list against the held heads.
    send_item(make_item(!end_sel, 1'b1, VAL_MIN, 1'b0));
    for (int k = 0; k < 4; k++)
      send_item(make_item(!end_sel, 1'b1, next_value(!end_sel), 1'b0));
    wait_drained();
    // Bare end mark on the empty list: drain the rest and complete.
    send_item(make_item(!end_sel, 1'b0, '0, 1'b1));
    // After completion every item is dropped.
    for (int k = 0; k < 6; k++)
      send_item(make_item($urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1, $urandom,
                          $urandom_range(0, 1) == 1));

    item_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb_sorted_stream_merge passed");
    end else begin
      $display("tb_sorted_stream_merge failed");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #4_000_000;
    $display("tb_sorted_stream_merge failed");
    $finish;
  end

endmodule
